FILE: rtl/core/asrp_pkg.sv
// package for the audio sampler record/play unit
// holds mode and command codes, register indexes, reset values and stage structs
// no dependencies
`timescale 1ns / 1ps

package asrp_pkg;

  // run mode of the sampler
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_REC  = 2'd1,
    MODE_PLAY = 2'd2
  } mode_t;

  // command carried in tuser
  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_REC  = 2'd1,
    CMD_PLAY = 2'd2,
    CMD_STOP = 2'd3
  } cmd_t;

  // register indexes (byte address 4*index)
  localparam logic [1:0] REG_MAX_LEN   = 2'd0;
  localparam logic [1:0] REG_LOOP      = 2'd1;
  localparam logic [1:0] REG_REVERSE   = 2'd2;
  localparam logic [1:0] REG_PHASE_INC = 2'd3;

  // register reset values
  localparam logic [15:0] MAX_LEN_RESET   = 16'd65534;
  localparam logic [30:0] PHASE_INC_RESET = 31'd8388608;

  // output queue size, also the credit limit at the input
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;

  // one item leaving the control stage
  typedef struct packed {
    logic        has_res;
    logic        play;
    logic [16:0] loc;
    logic [15:0] scale;
  } tick_t;

  // play range seen by the address stage
  typedef struct packed {
    logic        rev;
    logic [15:0] rec_len;
    logic [15:0] play_end;
  } span_t;

  // first sample and weight handed to the blend stage
  typedef struct packed {
    logic        has_res;
    logic        play;
    logic [15:0] v1;
    logic [15:0] scale;
  } pair_t;

endpackage

FILE: rtl/core/audio_sampler_record_play_unit.sv
// audio sampler record/play unit, top level
// path: an accepted beat passes the holding register, read slot, pair register and
//   product register into the output queue; the two sample reads per tick share
//   the single ram read port, and the next tick may enter during the neighbor read
// reset: synchronous, clears mode, indexes, lengths and registers to defaults;
//   the sample memory is not cleared and needs no pass. MEM_DEPTH is a power of two
`timescale 1ns / 1ps

module audio_sampler_record_play_unit #(
  parameter int MEM_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] in_sample
  input  logic [2:0]  s_axis_tuser,   // [1:0] command, [2] in_present
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] out_sample
);

  import asrp_pkg::*;

  localparam int AW = $clog2(MEM_DEPTH);

  logic          s0_free;
  logic          s1_free;
  logic          in_take;
  logic          tick_valid;
  tick_t         tick;
  span_t         span;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_data;
  logic          pair_valid;
  pair_t         pair;
  logic          push;
  logic [15:0]   push_data;
  logic [OQ_AW:0] credits;
  logic          res_in;
  logic          res_out;

  assign pready = 1'b1;

  // credits bound the results in flight to the queue size
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = s0_free && (credits < (OQ_AW + 1)'(OQ_DEPTH));
  assign res_in        = in_take && (cmd_t'(s_axis_tuser[1:0]) == CMD_TICK);
  assign res_out       = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      case ({res_in, res_out})
        2'b10:   credits <= credits + 1'b1;
        2'b01:   credits <= credits - 1'b1;
        default: ;
      endcase
    end
  end

  asrp_ctrl #(
    .AW(AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .in_take    (in_take),
    .in_cmd     (cmd_t'(s_axis_tuser[1:0])),
    .in_present (s_axis_tuser[2]),
    .in_sample  (s_axis_tdata),
    .s0_free    (s0_free),
    .s1_free    (s1_free),
    .tick_valid (tick_valid),
    .tick       (tick),
    .span       (span),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  asrp_ram #(
    .WIDTH (16),
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  asrp_fetch #(
    .AW(AW)
  ) u_fetch (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick       (tick),
    .span       (span),
    .s1_free    (s1_free),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .pair_valid (pair_valid),
    .pair       (pair)
  );

  asrp_blend u_blend (
    .clk        (clk),
    .rst        (rst),
    .pair_valid (pair_valid),
    .pair       (pair),
    .rd_data    (rd_data),
    .push       (push),
    .push_data  (push_data)
  );

  asrp_outq u_outq (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .push_data     (push_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

FILE: rtl/core/asrp_ram.sv
// generic simple dual port ram, one write port, one registered read port
// read returns old data on a same-address write; no dependencies
`timescale 1ns / 1ps

module asrp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/asrp_ctrl.sv
// control stage: config registers, sampler state, command decode, record writes
// depends on asrp_pkg
`timescale 1ns / 1ps

module asrp_ctrl #(
  parameter int AW = 16
) (
  input  logic               clk,
  input  logic               rst,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  // incoming beat
  input  logic               in_take,
  input  asrp_pkg::cmd_t     in_cmd,
  input  logic               in_present,
  input  logic [15:0]        in_sample,
  output logic               s0_free,
  // toward the address stage
  input  logic               s1_free,
  output logic               tick_valid,
  output asrp_pkg::tick_t    tick,
  output asrp_pkg::span_t    span,
  // sample memory write port
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [15:0]        wr_data
);

  import asrp_pkg::*;

  // config registers
  logic [15:0] max_len;
  logic        loop_en;
  logic        reverse;
  logic [30:0] phase_inc;

  // sampler state
  mode_t       run_mode, run_mode_next;
  logic [15:0] rec_addr, rec_addr_next;
  logic [15:0] rec_len, rec_len_next;
  logic [15:0] play_end, play_end_next;
  logic [30:0] phase, phase_next;
  logic [7:0]  fine_index, fine_index_next;
  logic [15:0] coarse_index, coarse_index_next;

  // held item
  logic        s0_valid;
  cmd_t        s0_cmd;
  logic        s0_present;
  logic [15:0] s0_sample;

  logic        s0_adv;
  logic        rec_write;
  logic [7:0]  fine_new;
  logic        wrap;
  logic [15:0] coarse_w;
  logic [16:0] idx;
  logic        end_hit;
  logic [30:0] phase_sum;

  assign s0_adv     = s0_valid && s1_free;
  assign s0_free    = !s0_valid || s1_free;
  assign tick_valid = s0_adv;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len   <= MAX_LEN_RESET;
      loop_en   <= 1'b0;
      reverse   <= 1'b0;
      phase_inc <= PHASE_INC_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_MAX_LEN:   max_len   <= pwdata[15:0];
        REG_LOOP:      loop_en   <= pwdata[0];
        REG_REVERSE:   reverse   <= pwdata[0];
        REG_PHASE_INC: phase_inc <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // config reads
  always_comb begin
    case (paddr[3:2])
      REG_MAX_LEN:   prdata = {16'd0, max_len};
      REG_LOOP:      prdata = {31'd0, loop_en};
      REG_REVERSE:   prdata = {31'd0, reverse};
      REG_PHASE_INC: prdata = {1'b0, phase_inc};
      default:       prdata = 32'd0;
    endcase
  end

  // item holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_take) begin
      s0_valid <= 1'b1;
    end else if (s0_adv) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_cmd     <= in_cmd;
      s0_present <= in_present;
      s0_sample  <= in_sample;
    end
  end

  // phase to index step of a playback tick
  assign fine_new  = phase[30:23];
  assign wrap      = (fine_index > 8'd128) && (fine_new < 8'd128);
  assign coarse_w  = wrap ? coarse_index + 16'd256 : coarse_index;
  assign idx       = {1'b0, coarse_w} + {9'd0, fine_new};
  assign end_hit   = idx >= {1'b0, play_end};
  assign phase_sum = phase + phase_inc;

  // next state of the sampler
  always_comb begin
    run_mode_next     = run_mode;
    rec_addr_next     = rec_addr;
    rec_len_next      = rec_len;
    play_end_next     = play_end;
    phase_next        = phase;
    fine_index_next   = fine_index;
    coarse_index_next = coarse_index;
    rec_write         = 1'b0;
    tick              = '0;

    if (s0_cmd != CMD_TICK && run_mode == MODE_REC) begin
      // commit the recording under way
      rec_len_next  = rec_addr;
      play_end_next = rec_addr;
    end

    case (s0_cmd)
      CMD_REC: begin
        run_mode_next = MODE_REC;
        rec_addr_next = 16'd0;
      end
      CMD_PLAY: begin
        run_mode_next     = MODE_PLAY;
        phase_next        = 31'd0;
        fine_index_next   = 8'd0;
        coarse_index_next = 16'd0;
      end
      CMD_STOP: begin
        run_mode_next = MODE_IDLE;
      end
      default: begin
        tick.has_res = 1'b1;
        case (run_mode)
          MODE_REC: begin
            if (s0_present) begin
              rec_write     = 1'b1;
              rec_addr_next = rec_addr + 16'd1;
              if (rec_addr >= max_len) begin
                // automatic stop at the length limit
                rec_len_next  = max_len;
                play_end_next = max_len;
                run_mode_next = MODE_IDLE;
              end
            end
          end
          MODE_PLAY: begin
            tick.play       = 1'b1;
            fine_index_next = fine_new;
            if (end_hit) begin
              // end of play range: restart from the top, or go idle if loop is off
              coarse_index_next = 16'd0;
              phase_next        = phase_inc;
              tick.loc          = {9'd0, fine_new};
              tick.scale        = 16'd0;
              if (!loop_en) begin
                run_mode_next = MODE_IDLE;
              end
            end else begin
              coarse_index_next = coarse_w;
              phase_next        = phase_sum;
              tick.loc          = idx;
              tick.scale        = phase[22:7];
            end
          end
          default: ;
        endcase
      end
    endcase
  end

  // state update when the item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode     <= MODE_IDLE;
      rec_addr     <= 16'd0;
      rec_len      <= 16'd0;
      play_end     <= 16'd0;
      phase        <= 31'd0;
      fine_index   <= 8'd0;
      coarse_index <= 16'd0;
    end else if (s0_adv) begin
      run_mode     <= run_mode_next;
      rec_addr     <= rec_addr_next;
      rec_len      <= rec_len_next;
      play_end     <= play_end_next;
      phase        <= phase_next;
      fine_index   <= fine_index_next;
      coarse_index <= coarse_index_next;
    end
  end

  // record write port
  assign wr_en   = s0_adv && rec_write;
  assign wr_addr = AW'(rec_addr);
  assign wr_data = s0_sample;

  assign span.rev      = reverse;
  assign span.rec_len  = rec_len;
  assign span.play_end = play_end;

endmodule

FILE: rtl/core/asrp_fetch.sv
// address stage: forms the two read locations and issues them on one read port
// depends on asrp_pkg; drives the read side of asrp_ram
`timescale 1ns / 1ps

module asrp_fetch #(
  parameter int AW = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             tick_valid,
  input  asrp_pkg::tick_t  tick,
  input  asrp_pkg::span_t  span,
  output logic             s1_free,
  output logic [AW-1:0]    rd_addr,
  input  logic [15:0]      rd_data,
  output logic             pair_valid,
  output asrp_pkg::pair_t  pair
);

  import asrp_pkg::*;

  logic               s1_valid;
  logic               s1_ph;
  tick_t              s1_tick;
  logic [15:0]        nxt_addr;

  logic signed [17:0] loc_s;
  logic signed [17:0] nxt_raw;
  logic signed [17:0] nxt_lo;
  logic signed [17:0] nxt_c;
  logic signed [17:0] pe_s;

  assign s1_free = !s1_valid || s1_ph;

  // read slot: first read, then neighbor read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_ph    <= 1'b0;
    end else if (tick_valid) begin
      s1_valid <= 1'b1;
      s1_ph    <= 1'b0;
    end else if (s1_valid && !s1_ph) begin
      s1_ph <= 1'b1;
    end else begin
      s1_valid <= 1'b0;
      s1_ph    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid) begin
      s1_tick <= tick;
    end
  end

  // location and clamped neighbor, forward or reverse
  assign pe_s  = $signed({2'b00, span.play_end});
  assign loc_s = span.rev ? $signed({2'b00, span.rec_len}) - $signed({1'b0, s1_tick.loc})
                          : $signed({1'b0, s1_tick.loc});
  assign nxt_raw = span.rev
      ? $signed({2'b00, span.rec_len}) - $signed({1'b0, s1_tick.loc}) - 18'sd1
      : $signed({1'b0, s1_tick.loc}) + 18'sd1;
  assign nxt_lo = (nxt_raw < 18'sd1) ? 18'sd1 : nxt_raw;
  assign nxt_c  = (nxt_lo > pe_s) ? pe_s : nxt_lo;

  always_ff @(posedge clk) begin
    if (s1_valid && !s1_ph) begin
      nxt_addr <= nxt_c[15:0];
    end
  end

  // read port: location first, neighbor second
  assign rd_addr = s1_ph ? AW'(nxt_addr) : AW'(loc_s[15:0]);

  // first sample is back during the neighbor-read phase of the slot
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
    end else begin
      pair_valid <= s1_valid && s1_ph;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ph) begin
      pair.has_res <= s1_tick.has_res;
      pair.play    <= s1_tick.play;
      pair.v1      <= rd_data;
      pair.scale   <= s1_tick.scale;
    end
  end

endmodule

FILE: rtl/core/asrp_blend.sv
// blend stage: linear interpolation of two samples by a 16-bit weight
// depends on asrp_pkg; takes the neighbor sample straight from the ram read port
`timescale 1ns / 1ps

module asrp_blend (
  input  logic             clk,
  input  logic             rst,
  input  logic             pair_valid,
  input  asrp_pkg::pair_t  pair,
  input  logic [15:0]      rd_data,
  output logic             push,
  output logic [15:0]      push_data
);

  import asrp_pkg::*;

  logic               p_valid;
  logic               p_has_res;
  logic               p_play;
  logic signed [32:0] prod1;
  logic signed [32:0] prod2;
  logic signed [33:0] sum;
  logic [15:0]        w_inv;

  assign w_inv = 16'hFFFF - pair.scale;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= pair_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_valid) begin
      p_has_res <= pair.has_res;
      p_play    <= pair.play;
      prod1     <= $signed(pair.v1) * $signed({1'b0, w_inv});
      prod2     <= $signed(rd_data) * $signed({1'b0, pair.scale});
    end
  end

  // sum and floor shift by 16
  assign sum       = {prod1[32], prod1} + {prod2[32], prod2};
  assign push      = p_valid && p_has_res;
  assign push_data = p_play ? sum[31:16] : 16'd0;

endmodule

FILE: rtl/core/asrp_outq.sv
// small output queue in front of the master stream port
// depends on asrp_pkg for its depth
`timescale 1ns / 1ps

module asrp_outq (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [15:0] push_data,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata
);

  import asrp_pkg::*;

  logic [15:0]      q [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr;
  logic [OQ_AW-1:0] rd_ptr;
  logic [OQ_AW:0]   count;
  logic             pop;

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = count != '0;
  assign m_axis_tdata  = q[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  // entry write
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

endmodule
